FILE: rtl/core/mssc_pkg.sv
// ----------------------------------------------------------------------------
// mssc_pkg
// Shared types and constants for the multi-channel servo slew controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mssc_pkg;

    // width of the attached mask register, fixed by the register map
    localparam int MASK_W = 9;
    localparam logic [7:0] ANGLE_MAX = 8'd180;
    localparam logic [7:0] ANGLE_MIN = 8'd0;

    // action codes
    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [3:0]        channel;
        logic signed [15:0] angle;
    } in_item_t;

    typedef struct packed {
        logic [3:0] channel_res;
        logic [7:0] angle_res;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic set_exec;
        logic scan_exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_tick;
        logic slot_free;
        logic pend_here;
        logic pend_none;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mssc_ctrl.sv
// ----------------------------------------------------------------------------
// mssc_ctrl
// Sequencer: takes a request, then runs either a set-angle update or a
// channel scan for a tick, issuing one command per cycle to the datapath unless a held output stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module mssc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mssc_pkg::dp_status_t status,
    output mssc_pkg::ctrl_cmd_t      cmd
);
    import mssc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SET  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.req_tick ? ST_SCAN : ST_SET;
                end
            end
            ST_SET:
            begin
                if (status.slot_free)
                begin
                    cmd.set_exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.pend_none)
                    state_next = ST_IDLE;
                else if (!status.pend_here || status.slot_free)
                    cmd.scan_exec = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/mssc_datapath.sv
// ----------------------------------------------------------------------------
// mssc_datapath
// Channel state bank, pending-move snapshot, scan counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mssc_datapath #(
    parameter int NUM_CHANNELS = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mssc_pkg::in_item_t    in_data,
    input  wire logic                  cfg_valid,
    input  wire logic [mssc_pkg::MASK_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output mssc_pkg::out_item_t        out_data,
    input  wire mssc_pkg::ctrl_cmd_t   cmd,
    output mssc_pkg::dp_status_t       status
);
    import mssc_pkg::*;

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [MASK_W-1:0]       mask_reg;
    in_item_t                item_reg;
    logic [7:0]              target_reg  [NUM_CHANNELS];
    logic [7:0]              current_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] cmd_vec_reg;
    logic [NUM_CHANNELS-1:0] pend_reg;
    logic [IW-1:0]           scan_idx_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic [NUM_CHANNELS+MASK_W-1:0] mask_ext;
    logic [NUM_CHANNELS-1:0] attached;
    logic [NUM_CHANNELS-1:0] move_mask;
    logic [NUM_CHANNELS-1:0] pend_rest;
    logic [3:0]              chan_m1;
    logic                    chan_ok;
    logic [IW-1:0]           addr;
    logic [7:0]              cur_rd;
    logic [7:0]              tgt_rd;
    logic [7:0]              stepped;
    logic [7:0]              clamped;
    logic                    slot_free;
    logic                    scan_move;
    logic                    set_emit;

    // channels beyond the mask width are never attached
    assign mask_ext = {{NUM_CHANNELS{1'b0}}, mask_reg};
    assign attached = mask_ext[NUM_CHANNELS-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            move_mask[i] = attached[i] && cmd_vec_reg[i]
                           && (current_reg[i] != target_reg[i]);
    end

    assign chan_m1 = item_reg.channel - 4'd1;
    assign chan_ok = (item_reg.channel != 4'd0)
                     && (32'(item_reg.channel) <= 32'(NUM_CHANNELS));
    assign addr    = (item_reg.action == ACT_TICK) ? scan_idx_reg : chan_m1[IW-1:0];
    assign cur_rd  = current_reg[addr];
    assign tgt_rd  = target_reg[addr];
    assign stepped = (tgt_rd > cur_rd) ? cur_rd + 8'd1 : cur_rd - 8'd1;

    always_comb
    begin
        if (item_reg.angle < 16'sd0)
            clamped = ANGLE_MIN;
        else if (item_reg.angle > 16'sd180)
            clamped = ANGLE_MAX;
        else
            clamped = item_reg.angle[7:0];
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign pend_rest = pend_reg & ~(NUM_CHANNELS'(1) << scan_idx_reg);
    assign scan_move = cmd.scan_exec && pend_reg[scan_idx_reg];
    assign set_emit  = cmd.set_exec && chan_ok && !cmd_vec_reg[addr] && attached[addr];

    always_comb
    begin
        status.req_tick  = (in_data.action == ACT_TICK);
        status.slot_free = slot_free;
        status.pend_here = pend_reg[scan_idx_reg];
        status.pend_none = (pend_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            cmd_vec_reg   <= '0;
            pend_reg      <= '0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                target_reg[i]  <= '0;
                current_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                mask_reg <= cfg_data;

            if (cmd.load)
            begin
                pend_reg     <= move_mask;
                scan_idx_reg <= '0;
            end

            if (cmd.set_exec && chan_ok)
            begin
                target_reg[addr] <= clamped;
                if (!cmd_vec_reg[addr])
                begin
                    cmd_vec_reg[addr] <= 1'b1;
                    current_reg[addr] <= clamped;
                end
            end

            if (cmd.scan_exec)
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
                if (pend_reg[scan_idx_reg])
                begin
                    current_reg[addr] <= stepped;
                    pend_reg          <= pend_rest;
                end
            end

            if (scan_move || set_emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (set_emit)
        begin
            out_data_reg.channel_res <= item_reg.channel;
            out_data_reg.angle_res   <= clamped;
            out_data_reg.last        <= 1'b1;
        end
        else if (scan_move)
        begin
            out_data_reg.channel_res <= 4'(scan_idx_reg) + 4'd1;
            out_data_reg.angle_res   <= stepped;
            out_data_reg.last        <= (pend_rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_move || set_emit) |-> slot_free)
        else $error("result loaded over an untaken result");

    a_cmd_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((~$past(cmd_vec_reg) | cmd_vec_reg) == {NUM_CHANNELS{1'b1}}))
        else $error("commanded flag cleared");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.angle_res <= ANGLE_MAX))
        else $error("written angle above limit");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_move && (pend_rest == '0)) |=> (pend_reg == '0))
        else $error("moves left pending after last write");

endmodule

`default_nettype wire

FILE: rtl/core/multi_servo_slew_controller.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_controller
// Bank of servo channels with a one-degree-per-tick slew limit.
//
// in_*   : requests, either set-angle (channel 1..N, angle clamped to 0..180)
//          or tick. A set-angle for channel 0 or above N is dropped.
// out_*  : servo writes (channel, angle); last marks the final write of a
//          request. A request may cause no write at all.
// cfg_*  : attached mask, one bit per channel; always ready. The user must write
//          it only while the block is idle; the block does not enforce this.
// A set-angle waits until the output register is free, loads its write (if
// any) into it and goes back to idle, where the input is ready again.
// A tick walks the scan counter over the channels, one channel per cycle
// unless a held write stalls it at a moving channel, up to the last channel
// that moves, then sees nothing left pending and goes back to idle.
// The single output register holds a write while out_ready is low; the scan
// then waits at the next channel that moves, and no new request is taken meanwhile.
// Reset clears all targets, current angles, commanded flags and the mask.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_servo_slew_controller #(
    parameter int NUM_CHANNELS = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire mssc_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output mssc_pkg::out_item_t                out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mssc_pkg::MASK_W-1:0]   cfg_data
);
    import mssc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mssc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel servo slew controller. A table of
// set-angle and tick requests runs first, then random requests under several
// attached masks. Every request accepted is run through a local model of the
// channel bank, and the servo writes that come out are checked in order.
// Both sides pause at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mssc_pkg::*;

    localparam int NCH             = 9;
    localparam int SETTLE_CYCLES   = NCH + 4;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int MASK_SWITCH_ROW = 2;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_ONE_WRITE
    } row_kind_t;

    typedef struct {
        in_item_t  req;
        row_kind_t kind;
        out_item_t want;
    } step_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MASK_W-1:0]   cfg_data;

    // model of the channel bank
    logic [7:0]          target_deg [NCH];
    logic [7:0]          current_deg [NCH];
    logic                commanded [NCH];
    logic [MASK_W-1:0]   attached_bits;

    out_item_t           step_writes[$];
    out_item_t           servo_writes_due[$];

    // how the request now on the input is to be checked
    row_kind_t           row_kind;
    out_item_t           row_write;

    bit                  calm;
    int                  fail_count;

    step_row_t           directed_rows [24];

    multi_servo_slew_controller #(
        .NUM_CHANNELS (NCH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // writes that one request causes, in the order the bank scans them
    function automatic void forecast_servo_writes(in_item_t req);
        int         ask;
        int         idx;
        logic [7:0] deg;
        out_item_t  w;
        step_writes.delete();
        if (req.action == ACT_SET)
        begin
            if (req.channel >= 1 && req.channel <= NCH)
            begin
                idx = req.channel - 1;
                ask = req.angle;
                if (ask < int'(ANGLE_MIN))
                    deg = ANGLE_MIN;
                else if (ask > int'(ANGLE_MAX))
                    deg = ANGLE_MAX;
                else
                    deg = ask[7:0];
                target_deg[idx] = deg;
                if (!commanded[idx])
                begin
                    commanded[idx] = 1'b1;
                    current_deg[idx] = deg;
                    if (attached_bits[idx])
                    begin
                        w.channel_res = req.channel;
                        w.angle_res = deg;
                        w.last = 1'b0;
                        step_writes.push_back(w);
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < NCH; i++)
            begin
                if (attached_bits[i] && commanded[i] && current_deg[i] != target_deg[i])
                begin
                    if (target_deg[i] > current_deg[i])
                        current_deg[i] = current_deg[i] + 8'd1;
                    else
                        current_deg[i] = current_deg[i] - 8'd1;
                    w.channel_res = 4'(i + 1);
                    w.angle_res = current_deg[i];
                    w.last = 1'b0;
                    step_writes.push_back(w);
                end
            end
        end
        if (step_writes.size() != 0)
            step_writes[step_writes.size() - 1].last = 1'b1;
    endfunction

    function automatic step_row_t mk_row(row_kind_t kind, logic act, logic [3:0] ch,
                                         int ang, logic [7:0] want_deg);
        step_row_t r;
        r.req.action = act;
        r.req.channel = ch;
        r.req.angle = 16'(ang);
        r.kind = kind;
        r.want.channel_res = ch;
        r.want.angle_res = want_deg;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        req.action = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_SET;
        if ($urandom_range(0, 99) < 85)
            req.channel = 4'($urandom_range(1, NCH));
        else
            req.channel = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req.angle = 16'($urandom_range(0, 180));
        else if (pick < 80)
            req.angle = 16'(int'($urandom_range(0, 60)) - 30);
        else if (pick < 88)
            req.angle = 16'($urandom_range(170, 260));
        else
            req.angle = 16'($urandom());
        return req;
    endfunction

    // entered and left on a falling edge
    task automatic send_request(in_item_t req, row_kind_t kind, out_item_t want);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= req;
        row_kind  <= kind;
        row_write <= want;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (servo_writes_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_attached_mask(logic [MASK_W-1:0] bits);
        hold_until_drained();
        // a request with no write may still be scanning
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
                hold = pick_gap();
            if (hold == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                hold--;
            end
        end
    end

    always @(posedge clk)
    begin : observe
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (servo_writes_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected write ch=%0d ang=%0d last=%0b", $time,
                             out_data.channel_res, out_data.angle_res, out_data.last);
                end
                else
                begin
                    want = servo_writes_due.pop_front();
                    if (out_data !== want)
                    begin
                        fail_count++;
                        $display("%0t: want ch=%0d ang=%0d last=%0b got ch=%0d ang=%0d last=%0b",
                                 $time, want.channel_res, want.angle_res, want.last,
                                 out_data.channel_res, out_data.angle_res, out_data.last);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                forecast_servo_writes(in_data);
                if (row_kind == ROW_SILENT)
                    step_writes.delete();
                else if (row_kind == ROW_ONE_WRITE)
                    step_writes = '{row_write};
                foreach (step_writes[i])
                    servo_writes_due.push_back(step_writes[i]);
            end
            if (cfg_valid && cfg_ready)
                attached_bits = cfg_data;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [MASK_W-1:0] mask_plan [7];

        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        row_kind  = ROW_PREDICTED;
        row_write = '0;
        calm      = 1'b0;
        fail_count = 0;
        attached_bits = '0;
        for (int i = 0; i < NCH; i++)
        begin
            target_deg[i]  = 8'd0;
            current_deg[i] = 8'd0;
            commanded[i]   = 1'b0;
        end

        // first two rows run with nothing attached
        directed_rows = '{
            mk_row(ROW_SILENT,    ACT_TICK, 4'd0,  0,      8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd1,  90,     8'd0),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd2,  0,      8'd0),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd3,  180,    8'd180),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd4,  -32768, 8'd0),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd5,  32767,  8'd180),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd6,  181,    8'd180),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd7,  -1,     8'd0),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd9,  45,     8'd45),
            mk_row(ROW_SILENT,    ACT_SET,  4'd0,  50,     8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd10, 50,     8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd15, 100,    8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd2,  10,     8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd3,  178,    8'd0),
            mk_row(ROW_PREDICTED, ACT_TICK, 4'd0,  0,      8'd0),
            mk_row(ROW_PREDICTED, ACT_TICK, 4'd0,  0,      8'd0),
            mk_row(ROW_ONE_WRITE, ACT_SET,  4'd8,  180,    8'd180),
            mk_row(ROW_SILENT,    ACT_SET,  4'd4,  180,    8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd5,  0,      8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd1,  0,      8'd0),
            mk_row(ROW_PREDICTED, ACT_TICK, 4'd15, -1,     8'd0),
            mk_row(ROW_PREDICTED, ACT_TICK, 4'd0,  21845,  8'd0),
            mk_row(ROW_SILENT,    ACT_SET,  4'd9,  180,    8'd0),
            mk_row(ROW_PREDICTED, ACT_TICK, 4'd9,  0,      8'd0)
        };

        mask_plan = '{9'h1FF, 9'($urandom), 9'h000, 9'h155, 9'($urandom), 9'h0AA, 9'h1FF};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            if (r == MASK_SWITCH_ROW)
                write_attached_mask(9'h1FF);
            send_request(directed_rows[r].req, directed_rows[r].kind, directed_rows[r].want);
        end

        foreach (mask_plan[p])
        begin
            write_attached_mask(mask_plan[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k % 16 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // let the output side run dry now and then
                if ($urandom_range(0, 39) == 0)
                    hold_until_drained();
                send_request(random_request(), ROW_PREDICTED, '0);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: multi_servo_slew_controller.f
rtl/core/mssc_pkg.sv
rtl/core/mssc_ctrl.sv
rtl/core/mssc_datapath.sv
rtl/core/multi_servo_slew_controller.sv
bench/tb_top.sv
